// ----- rtl/tchd_pkg.sv -----
// Shared types and constants for the tilt-compensated heading core.
// Holds the port word structs, the flag bundle and the arctangent table.
// No dependencies.
package tchd_pkg;

    // One sensor sample word.
    typedef struct packed {
        logic signed [14:0] pitch_centideg;
        logic signed [15:0] roll_centideg;
        logic signed [15:0] mag_x;
        logic signed [15:0] mag_y;
        logic signed [15:0] mag_z;
    } tchd_sample_t;

    // One heading result word.
    typedef struct packed {
        logic [15:0] heading_centideg;
        logic        valid_res;
    } tchd_heading_t;

    // Quadrant flags that travel beside the vectoring pipeline.
    typedef struct packed {
        logic vld;
        logic hx_pos;
        logic hx_zero;
        logic hy_pos;
        logic hy_neg;
    } tchd_flags_t;

    // CORDIC gain reciprocal 0.60725293500888 in Q30.
    localparam longint INV_GAIN_Q30 = 64'sd652032874;

    // Fraction bits of the arctangent table.
    localparam int TAB_FRAC = 24;

    // round(atan(2^-i) in centidegrees * 2^24).
    function automatic logic [39:0] tchd_atan(input int unsigned i);
        logic [39:0] v;
        case (i)
            0:       v = 40'd75497472000;
            1:       v = 40'd44568760165;
            2:       v = 40'd23548908849;
            3:       v = 40'd11953793829;
            4:       v = 40'd6000093430;
            5:       v = 40'd3002971690;
            6:       v = 40'd1501852269;
            7:       v = 40'd750971963;
            8:       v = 40'd375491711;
            9:       v = 40'd187746572;
            10:      v = 40'd93873375;
            11:      v = 40'd46936699;
            12:      v = 40'd23468351;
            13:      v = 40'd11734176;
            14:      v = 40'd5867088;
            15:      v = 40'd2933544;
            16:      v = 40'd1466772;
            17:      v = 40'd733386;
            18:      v = 40'd366693;
            19:      v = 40'd183346;
            20:      v = 40'd91673;
            21:      v = 40'd45837;
            22:      v = 40'd22918;
            23:      v = 40'd11459;
            default: v = 40'd0;
        endcase
        return v;
    endfunction

endpackage

// ----- rtl/tchd_rot.sv -----
// Pipelined rotation CORDIC that gives sine and cosine of an angle in centidegrees.
// Depends on tchd_pkg for the gain constant and the arctangent table.
// Registers: the input stage, the micro-rotation stages and the output stage.
module tchd_rot
    import tchd_pkg::*;
#(
    parameter int STAGES = 18,
    parameter int FRAC   = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic signed [15:0]    angle,
    output logic signed [FRAC+2:0] sin_q,
    output logic signed [FRAC+2:0] cos_q
);

    localparam int XW = FRAC + 3;
    localparam int ZW = FRAC + 16;
    localparam logic signed [XW-1:0] X_INIT = XW'(INV_GAIN_Q30 >>> (30 - FRAC));

    logic signed [16:0]   a_wide;
    logic signed [16:0]   a_wrap;
    logic signed [16:0]   a_fold;
    logic                 fold_next;
    logic signed [ZW-1:0] z_next;

    logic signed [XW-1:0] x_reg [0:STAGES];
    logic signed [XW-1:0] y_reg [0:STAGES];
    logic signed [ZW-1:0] z_reg [0:STAGES];
    logic                 flip_reg [0:STAGES];
    logic signed [XW-1:0] sin_reg;
    logic signed [XW-1:0] cos_reg;

    // Wrap the angle into (-18000, 18000], then fold it into the right half plane.
    always_comb
    begin
        a_wide = {angle[15], angle};
        if (a_wide <= -17'sd18000)
        begin
            a_wrap = a_wide + 17'sd36000;
        end
        else if (a_wide > 17'sd18000)
        begin
            a_wrap = a_wide - 17'sd36000;
        end
        else
        begin
            a_wrap = a_wide;
        end
        fold_next = 1'b0;
        a_fold    = a_wrap;
        if (a_wrap > 17'sd9000)
        begin
            a_fold    = a_wrap - 17'sd18000;
            fold_next = 1'b1;
        end
        else if (a_wrap < -17'sd9000)
        begin
            a_fold    = a_wrap + 17'sd18000;
            fold_next = 1'b1;
        end
        z_next = ZW'(a_fold) <<< FRAC;
    end

    // CORDIC micro-rotations, one per register stage.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]    <= X_INIT;
            y_reg[0]    <= '0;
            z_reg[0]    <= z_next;
            flip_reg[0] <= fold_next;
            for (int i = 0; i < STAGES; i++)
            begin
                if (!z_reg[i][ZW-1])
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - ZW'(tchd_atan(i) >> (TAB_FRAC - FRAC));
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + ZW'(tchd_atan(i) >> (TAB_FRAC - FRAC));
                end
                flip_reg[i+1] <= flip_reg[i];
            end
            // Undo the half-plane fold by negating both outputs.
            sin_reg <= flip_reg[STAGES] ? -y_reg[STAGES] : y_reg[STAGES];
            cos_reg <= flip_reg[STAGES] ? -x_reg[STAGES] : x_reg[STAGES];
        end
    end

    assign sin_q = sin_reg;
    assign cos_q = cos_reg;

    // The first-stage angle always lies within a quarter turn.
    a_zrange: assert property (@(posedge clk) disable iff (!rst_n)
        (a_fold <= 17'sd9000) && (a_fold >= -17'sd9000))
        else $error("folded angle out of range");

    // A fold is taken exactly when the wrapped angle lies beyond a quarter turn.
    a_fold_rule: assert property (@(posedge clk) disable iff (!rst_n)
        fold_next == ((a_wrap > 17'sd9000) || (a_wrap < -17'sd9000)))
        else $error("fold flag mismatch");

    // A held stage keeps the rotated outputs.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(sin_reg) && $stable(cos_reg))
        else $error("outputs moved while held");

endmodule

// ----- rtl/tchd_vec.sv -----
// Normalizing shifter and pipelined vectoring CORDIC for a first-quadrant vector.
// Depends on tchd_pkg for the arctangent table.
// The angle comes out of the vectoring stages clamped to a quarter turn.
module tchd_vec
    import tchd_pkg::*;
#(
    parameter int STAGES = 18,
    parameter int FRAC   = 16,
    parameter int IW     = 37
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic [IW-1:0]        x_in,
    input  logic [IW-1:0]        y_in,
    output logic [FRAC+13:0]     angle
);

    localparam int NW = (IW > 41) ? IW : 41;
    // The CORDIC gain grows the magnitude by about 1.65 on top of the diagonal.
    localparam int VW = NW + 3;
    localparam int ZW = FRAC + 16;
    localparam logic signed [ZW-1:0] QUARTER = ZW'(longint'(9000) << FRAC);

    logic [NW-1:0]        nx_reg [0:6];
    logic [NW-1:0]        ny_reg [0:6];
    logic signed [VW-1:0] vx_reg [0:STAGES];
    logic signed [VW-1:0] vy_reg [0:STAGES];
    logic signed [ZW-1:0] vz_reg [0:STAGES];
    logic signed [ZW-1:0] z_clamp;

    // Binary normalization: lift the larger component to at least 2^40.
    always_ff @(posedge clk)
    begin
        logic [NW-1:0] orv;
        int            sh;
        if (en)
        begin
            nx_reg[0] <= NW'(x_in);
            ny_reg[0] <= NW'(y_in);
            for (int k = 0; k < 6; k++)
            begin
                sh  = 32 >> k;
                orv = nx_reg[k] | ny_reg[k];
                if ((orv >> (41 - sh)) == '0)
                begin
                    nx_reg[k+1] <= nx_reg[k] << sh;
                    ny_reg[k+1] <= ny_reg[k] << sh;
                end
                else
                begin
                    nx_reg[k+1] <= nx_reg[k];
                    ny_reg[k+1] <= ny_reg[k];
                end
            end
        end
    end

    // Vectoring micro-rotations drive y toward zero and sum the angle.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vx_reg[0] <= VW'(nx_reg[6]);
            vy_reg[0] <= VW'(ny_reg[6]);
            vz_reg[0] <= '0;
            for (int i = 0; i < STAGES; i++)
            begin
                if (!vy_reg[i][VW-1] && (vy_reg[i] != '0))
                begin
                    vx_reg[i+1] <= vx_reg[i] + (vy_reg[i] >>> i);
                    vy_reg[i+1] <= vy_reg[i] - (vx_reg[i] >>> i);
                    vz_reg[i+1] <= vz_reg[i] + ZW'(tchd_atan(i) >> (TAB_FRAC - FRAC));
                end
                else
                begin
                    vx_reg[i+1] <= vx_reg[i] - (vy_reg[i] >>> i);
                    vy_reg[i+1] <= vy_reg[i] + (vx_reg[i] >>> i);
                    vz_reg[i+1] <= vz_reg[i] - ZW'(tchd_atan(i) >> (TAB_FRAC - FRAC));
                end
            end
        end
    end

    // Clamp the summed angle to 0..9000 centidegrees.
    always_comb
    begin
        if (vz_reg[STAGES][ZW-1])
        begin
            z_clamp = '0;
        end
        else if (vz_reg[STAGES] > QUARTER)
        begin
            z_clamp = QUARTER;
        end
        else
        begin
            z_clamp = vz_reg[STAGES];
        end
    end

    assign angle = z_clamp[FRAC+13:0];

    // Normalized components never carry into the guard bits.
    // The data path has no reset, so the check starts once real data arrives.
    a_norm_fit: assert property (@(posedge clk) disable iff (!rst_n)
        !$isunknown({vx_reg[0], vy_reg[0]}) |-> (!vx_reg[0][VW-1] && !vy_reg[0][VW-1]))
        else $error("normalized component overflow");

    // The clamped angle never exceeds a quarter turn.
    a_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        !$isunknown(vz_reg[STAGES]) |-> (z_clamp <= QUARTER))
        else $error("clamped angle too large");

    // A held pipeline keeps its final angle.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(vz_reg[STAGES]))
        else $error("angle moved while held");

endmodule

// ----- rtl/tilt_compensated_heading_core.sv -----
// Top level of the tilt-compensated compass heading core.
// Depends on tchd_pkg, tchd_rot and tchd_vec.
//
// Usage:
//   The sample channel (sample_valid, sample_stall, sample) takes one word with
//   pitch, roll and the three raw magnetometer axes. A word is taken at a clock
//   edge where sample_valid is high and sample_stall is low.
//   The heading channel (heading_valid, heading_stall, heading) gives one word per
//   sample: the heading 0..35999 in centidegrees, truncated, and valid_res, which
//   is 0 (with heading 0) when the horizontal field is zero.
//   Throughput is one word per cycle while the pipeline is not frozen. A word
//   reaches heading_valid through 2*CORDIC_STAGES + 14 register stages:
//   the rotation chain (CORDIC_STAGES + 2), three product and sum stages, the
//   normalizer and vectoring chain (CORDIC_STAGES + 8) and the output register.
//   When the receiver stalls, the finished word holds on the port, a second word
//   lands in a skid register, and the whole pipeline freezes while that register
//   is full; sample_stall is that register's full flag, so nothing is dropped.
//   Reset clears every valid bit; there is no configuration and no clearing pass.
module tilt_compensated_heading_core
    import tchd_pkg::*;
#(
    parameter int CORDIC_STAGES = 18,
    parameter int FRACTION_BITS = 16
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          sample_valid,
    output logic          sample_stall,
    input  tchd_sample_t  sample,
    output logic          heading_valid,
    input  logic          heading_stall,
    output tchd_heading_t heading
);

    localparam int F       = FRACTION_BITS;
    localparam int XW      = F + 3;
    localparam int PW      = XW + 16;
    localparam int HW      = PW + 2;
    localparam int AW      = F + 14;
    localparam int TW      = F + 17;
    localparam int ROT_LAT = CORDIC_STAGES + 2;
    localparam int VEC_LAT = CORDIC_STAGES + 8;
    localparam logic [TW-1:0] C9000  = TW'(longint'(9000) << F);
    localparam logic [TW-1:0] C18000 = TW'(longint'(18000) << F);
    localparam logic [TW-1:0] C27000 = TW'(longint'(27000) << F);
    localparam logic [TW-1:0] C36000 = TW'(longint'(36000) << F);

    logic pipe_en;

    // Sine and cosine of pitch and roll.
    logic signed [XW-1:0] sp;
    logic signed [XW-1:0] cp;
    logic signed [XW-1:0] sr;
    logic signed [XW-1:0] cr;

    tchd_rot #(.STAGES(CORDIC_STAGES), .FRAC(F)) u_rot_pitch (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (pipe_en),
        .angle ({sample.pitch_centideg[14], sample.pitch_centideg}),
        .sin_q (sp),
        .cos_q (cp)
    );

    tchd_rot #(.STAGES(CORDIC_STAGES), .FRAC(F)) u_rot_roll (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (pipe_en),
        .angle (sample.roll_centideg),
        .sin_q (sr),
        .cos_q (cr)
    );

    // Valid bits and field words travel beside the rotation pipeline.
    logic         vld_dly_reg [0:ROT_LAT-1];
    tchd_sample_t smp_dly_reg [0:ROT_LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < ROT_LAT; k++)
            begin
                vld_dly_reg[k] <= 1'b0;
            end
        end
        else if (pipe_en)
        begin
            vld_dly_reg[0] <= sample_valid;
            for (int k = 1; k < ROT_LAT; k++)
            begin
                vld_dly_reg[k] <= vld_dly_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            smp_dly_reg[0] <= sample;
            for (int k = 1; k < ROT_LAT; k++)
            begin
                smp_dly_reg[k] <= smp_dly_reg[k-1];
            end
        end
    end

    // Cross products of the roll and pitch terms.
    logic signed [2*XW-1:0] ss_full;
    logic signed [2*XW-1:0] sc_full;
    logic signed [XW-1:0]   ss_next;
    logic signed [XW-1:0]   sc_next;
    logic signed [XW-1:0]   ss_reg;
    logic signed [XW-1:0]   sc_reg;
    logic signed [XW-1:0]   cp_reg;
    logic signed [XW-1:0]   sp_reg;
    logic signed [XW-1:0]   cr_reg;
    logic                   vp_reg;
    tchd_sample_t           smp_p_reg;

    always_comb
    begin
        ss_full = sr * sp;
        sc_full = sr * cp;
        ss_next = XW'(ss_full >>> F);
        sc_next = XW'(sc_full >>> F);
    end

    // Field products, one per multiplier.
    logic signed [PW-1:0] p_mxcp_reg;
    logic signed [PW-1:0] p_mzsp_reg;
    logic signed [PW-1:0] p_mxss_reg;
    logic signed [PW-1:0] p_mycr_reg;
    logic signed [PW-1:0] p_mzsc_reg;
    logic                 vm_reg;

    // Horizontal field sums.
    logic signed [HW-1:0] hx_next;
    logic signed [HW-1:0] hy_next;
    logic signed [HW-1:0] hx_reg;
    logic signed [HW-1:0] hy_reg;
    logic                 vh_reg;

    always_comb
    begin
        hx_next = HW'(p_mxcp_reg) + HW'(p_mzsp_reg);
        hy_next = HW'(p_mxss_reg) + HW'(p_mycr_reg) - HW'(p_mzsc_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vp_reg <= 1'b0;
            vm_reg <= 1'b0;
            vh_reg <= 1'b0;
        end
        else if (pipe_en)
        begin
            vp_reg <= vld_dly_reg[ROT_LAT-1];
            vm_reg <= vp_reg;
            vh_reg <= vm_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            ss_reg     <= ss_next;
            sc_reg     <= sc_next;
            cp_reg     <= cp;
            sp_reg     <= sp;
            cr_reg     <= cr;
            smp_p_reg  <= smp_dly_reg[ROT_LAT-1];
            p_mxcp_reg <= smp_p_reg.mag_x * cp_reg;
            p_mzsp_reg <= smp_p_reg.mag_z * sp_reg;
            p_mxss_reg <= smp_p_reg.mag_x * ss_reg;
            p_mycr_reg <= smp_p_reg.mag_y * cr_reg;
            p_mzsc_reg <= smp_p_reg.mag_z * sc_reg;
            hx_reg     <= hx_next;
            hy_reg     <= hy_next;
        end
    end

    // Magnitudes into the vectoring unit, quadrant flags beside it.
    logic [HW-1:0] hx_abs;
    logic [HW-1:0] hy_abs;
    tchd_flags_t   flags_next;

    always_comb
    begin
        hx_abs             = hx_reg[HW-1] ? HW'(-hx_reg) : HW'(hx_reg);
        hy_abs             = hy_reg[HW-1] ? HW'(-hy_reg) : HW'(hy_reg);
        flags_next.vld     = vh_reg;
        flags_next.hx_zero = (hx_reg == '0);
        flags_next.hx_pos  = !hx_reg[HW-1] && (hx_reg != '0);
        flags_next.hy_pos  = !hy_reg[HW-1] && (hy_reg != '0);
        flags_next.hy_neg  = hy_reg[HW-1];
    end

    logic [AW-1:0] vec_angle;

    tchd_vec #(.STAGES(CORDIC_STAGES), .FRAC(F), .IW(HW)) u_vec (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (pipe_en),
        .x_in  (hx_abs),
        .y_in  (hy_abs),
        .angle (vec_angle)
    );

    tchd_flags_t flg_dly_reg [0:VEC_LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < VEC_LAT; k++)
            begin
                flg_dly_reg[k] <= '0;
            end
        end
        else if (pipe_en)
        begin
            flg_dly_reg[0] <= flags_next;
            for (int k = 1; k < VEC_LAT; k++)
            begin
                flg_dly_reg[k] <= flg_dly_reg[k-1];
            end
        end
    end

    // Quadrant mapping and the half-turn offset.
    tchd_flags_t   flg_tail;
    logic [TW-1:0] a_ext;
    logic [TW-1:0] h_quad;
    logic [TW-1:0] h_turn;
    tchd_heading_t res_next;

    always_comb
    begin
        flg_tail = flg_dly_reg[VEC_LAT-1];
        a_ext    = TW'(vec_angle);
        if (flg_tail.hx_zero)
        begin
            h_quad = flg_tail.hy_neg ? C9000 : C27000;
        end
        else if (flg_tail.hx_pos)
        begin
            h_quad = flg_tail.hy_pos ? a_ext : C36000 - a_ext;
        end
        else
        begin
            h_quad = flg_tail.hy_pos ? C18000 - a_ext : C18000 + a_ext;
        end
        h_turn = (h_quad < C18000) ? h_quad + C18000 : h_quad - C18000;
        if (flg_tail.hx_zero && !flg_tail.hy_pos && !flg_tail.hy_neg)
        begin
            res_next.heading_centideg = '0;
            res_next.valid_res        = 1'b0;
        end
        else
        begin
            res_next.heading_centideg = h_turn[F+15:F];
            res_next.valid_res        = 1'b1;
        end
    end

    // Output register with one skid word behind it.
    logic          push;
    logic          out_vld_reg;
    logic          skid_vld_reg;
    tchd_heading_t out_reg;
    tchd_heading_t skid_reg;

    assign pipe_en = !skid_vld_reg;
    assign push    = pipe_en && flg_tail.vld;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else if (!out_vld_reg || !heading_stall)
        begin
            out_vld_reg  <= skid_vld_reg || push;
            skid_vld_reg <= 1'b0;
        end
        else if (push)
        begin
            skid_vld_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_vld_reg || !heading_stall)
        begin
            out_reg <= skid_vld_reg ? skid_reg : res_next;
        end
        else if (push)
        begin
            skid_reg <= res_next;
        end
    end

    assign sample_stall  = skid_vld_reg;
    assign heading_valid = out_vld_reg;
    assign heading       = out_reg;

    // The skid word is only ever occupied behind a waiting output word.
    a_skid_behind: assert property (@(posedge clk) disable iff (!rst_n)
        skid_vld_reg |-> out_vld_reg)
        else $error("skid full with empty output");

    // A word marked invalid carries a zero heading.
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && !out_reg.valid_res) |-> (out_reg.heading_centideg == '0))
        else $error("invalid word with nonzero heading");

    // Headings stay below a full turn.
    a_heading_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg |-> (out_reg.heading_centideg <= 16'd35999))
        else $error("heading out of range");

    // A frozen pipeline holds its tail so the pending word is not lost.
    a_tail_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !pipe_en |=> $stable(flg_dly_reg[VEC_LAT-1]))
        else $error("pipeline tail moved while frozen");

endmodule

// ----- sim/tchd_heading_checker.sv -----
// Checker for the tilt-compensated heading core: watches both channels,
// predicts each heading word in fixed point and compares. Depends on tchd_pkg.
`timescale 1ns / 100ps
module tchd_heading_checker
    import tchd_pkg::*;
#(
    parameter int CORDIC_STAGES = 18,
    parameter int FRACTION_BITS = 16
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          sample_valid,
    input  logic          sample_stall,
    input  tchd_sample_t  sample,
    input  logic          heading_valid,
    input  logic          heading_stall,
    input  tchd_heading_t heading,
    output int            fail_count,
    output int            pending_count,
    output int            heading_count
);

    tchd_heading_t expected_headings[$];

    // Floor shift right of a signed value.
    function automatic longint floor_shift(input longint v, input int s);
        return v >>> s;
    endfunction

    function automatic longint atan_step(input int i);
        return longint'(tchd_atan(i)) >>> (TAB_FRAC - FRACTION_BITS);
    endfunction

    // Rotation CORDIC giving sine and cosine of an angle in centidegrees.
    function automatic void sine_cosine(input longint c, output longint sn,
                                        output longint cs);
        longint r, x, y, z, dx, dy;
        bit     flip;
        r = c % 36000;
        flip = 0;
        if (r < 0) r += 36000;
        if (r > 18000) r -= 36000;
        if (r > 9000)
        begin
            r -= 18000;
            flip = 1;
        end
        else if (r < -9000)
        begin
            r += 18000;
            flip = 1;
        end
        x = INV_GAIN_Q30 >>> (30 - FRACTION_BITS);
        y = 0;
        z = r * (64'sd1 <<< FRACTION_BITS);
        for (int i = 0; i < CORDIC_STAGES && i < 24; i++)
        begin
            dx = floor_shift(y, i);
            dy = floor_shift(x, i);
            if (z >= 0)
            begin
                x -= dx; y += dy; z -= atan_step(i);
            end
            else
            begin
                x += dx; y -= dy; z += atan_step(i);
            end
        end
        if (flip)
        begin
            x = -x; y = -y;
        end
        sn = y;
        cs = x;
    endfunction

    // Vectoring CORDIC angle of a first-quadrant vector, clamped to 0..90 degrees.
    function automatic longint first_quadrant_angle(input longint x0, input longint y0);
        longint x, y, z, dx, dy;
        x = x0; y = y0; z = 0;
        while ((x > y ? x : y) < (64'sd1 <<< 40))
        begin
            x *= 2; y *= 2;
        end
        for (int i = 0; i < CORDIC_STAGES && i < 24; i++)
        begin
            dx = floor_shift(y, i);
            dy = floor_shift(x, i);
            if (y > 0)
            begin
                x += dx; y -= dy; z += atan_step(i);
            end
            else
            begin
                x -= dx; y += dy; z -= atan_step(i);
            end
        end
        if (z < 0) z = 0;
        if (z > (64'sd9000 <<< FRACTION_BITS)) z = 64'sd9000 <<< FRACTION_BITS;
        return z;
    endfunction

    function automatic tchd_heading_t predict_heading(input tchd_sample_t s);
        tchd_heading_t res;
        longint sp, cp, sr, cr, ss, sc, hx, hy, h, a, one;
        one = 64'sd1 <<< FRACTION_BITS;
        sine_cosine(longint'(s.pitch_centideg), sp, cp);
        sine_cosine(longint'(s.roll_centideg), sr, cr);
        ss = floor_shift(sr * sp, FRACTION_BITS);
        sc = floor_shift(sr * cp, FRACTION_BITS);
        hx = longint'(s.mag_x) * cp + longint'(s.mag_z) * sp;
        hy = longint'(s.mag_x) * ss + longint'(s.mag_y) * cr - longint'(s.mag_z) * sc;
        if (hx == 0 && hy == 0)
        begin
            res.heading_centideg = '0;
            res.valid_res = 1'b0;
            return res;
        end
        if (hx == 0)
            h = (hy < 0 ? 64'sd9000 : 64'sd27000) * one;
        else
        begin
            a = first_quadrant_angle(hx > 0 ? hx : -hx, hy > 0 ? hy : -hy);
            if (hx > 0)
                h = (hy > 0) ? a : 36000 * one - a;
            else
                h = (hy > 0) ? 18000 * one - a : 18000 * one + a;
        end
        if (h < 18000 * one) h += 18000 * one;
        else h -= 18000 * one;
        res.heading_centideg = 16'(h >>> FRACTION_BITS);
        res.valid_res = 1'b1;
        return res;
    endfunction

    // Predict on each accepted sample word and check each accepted heading word.
    always @(posedge clk or negedge rst_n)
    begin
        tchd_heading_t want;
        int            errs;
        errs = 0;
        if (!rst_n)
        begin
            fail_count    <= 0;
            heading_count <= 0;
            pending_count <= 0;
        end
        else
        begin
            if (heading_valid && !heading_stall)
            begin
                heading_count <= heading_count + 1;
                if (expected_headings.size() == 0)
                begin
                    $error("heading word with no sample waiting: %h", heading);
                    errs++;
                end
                else
                begin
                    want = expected_headings.pop_front();
                    if (want.heading_centideg !== heading.heading_centideg)
                    begin
                        $error("heading_centideg: expected %0d, got %0d",
                               want.heading_centideg, heading.heading_centideg);
                        errs++;
                    end
                    if (want.valid_res !== heading.valid_res)
                    begin
                        $error("valid_res: expected %0d, got %0d",
                               want.valid_res, heading.valid_res);
                        errs++;
                    end
                end
            end
            if (sample_valid && !sample_stall)
                expected_headings.push_back(predict_heading(sample));
            if (errs != 0)
                fail_count <= fail_count + errs;
            pending_count <= expected_headings.size();
        end
    end

endmodule

// ----- sim/tilt_compensated_heading_core_test.sv -----
// Testbench top for the tilt-compensated heading core: makes directed and
// random sample words with random idling and gives the verdict.
// Depends on tchd_pkg, tchd_heading_checker and the core.
`timescale 1ns / 100ps
module tilt_compensated_heading_core_test
    import tchd_pkg::*;
;

    localparam int LATENCY    = 2 * 18 + 15;
    localparam int IDLE_LIMIT = 4000;

    logic          clk;
    logic          rst_n;
    logic          sample_valid;
    logic          sample_stall;
    tchd_sample_t  sample;
    logic          heading_valid;
    logic          heading_stall;
    tchd_heading_t heading;
    int            fail_count;
    int            pending_count;
    int            heading_count;
    int            sample_count;
    int            idle_cycles;
    bit            busy_phase;

    tilt_compensated_heading_core dut (
        .clk(clk), .rst_n(rst_n),
        .sample_valid(sample_valid), .sample_stall(sample_stall), .sample(sample),
        .heading_valid(heading_valid), .heading_stall(heading_stall), .heading(heading)
    );

    tchd_heading_checker checker_i (
        .clk(clk), .rst_n(rst_n),
        .sample_valid(sample_valid), .sample_stall(sample_stall), .sample(sample),
        .heading_valid(heading_valid), .heading_stall(heading_stall), .heading(heading),
        .fail_count(fail_count), .pending_count(pending_count),
        .heading_count(heading_count)
    );

    initial
    begin
        clk = 0;
        forever #4 clk = ~clk;
    end

    // Receiver stalls about a third of the time, except during the busy phase.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            heading_stall <= 1'b0;
        else
            heading_stall <= busy_phase ? 1'b0 : ($urandom_range(99) < 35);
    end

    // Watchdog on cycles with no accepted word on either channel.
    always @(posedge clk)
    begin
        if ((sample_valid && !sample_stall) || (heading_valid && !heading_stall))
            idle_cycles <= 0;
        else if (rst_n)
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // Present one word and hold it until accepted; idle gaps come before it.
    task automatic send_sample(input tchd_sample_t s);
        while (!busy_phase && $urandom_range(99) < 35)
        begin
            sample_valid <= 1'b0;
            @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample       <= s;
        @(posedge clk);
        while (sample_stall)
            @(posedge clk);
        sample_count++;
    endtask

    task automatic send_fields(input int p, input int r, input int x, input int y,
                               input int z);
        tchd_sample_t s;
        s.pitch_centideg = 15'(p);
        s.roll_centideg  = 16'(r);
        s.mag_x = 16'(x);
        s.mag_y = 16'(y);
        s.mag_z = 16'(z);
        send_sample(s);
    endtask

    function automatic tchd_sample_t random_sample(input bit raw);
        tchd_sample_t s;
        s = '0;
        if (raw)
        begin
            s.pitch_centideg = 15'($urandom);
            s.roll_centideg  = 16'($urandom);
        end
        else
        begin
            s.pitch_centideg = 15'($signed($urandom_range(18000)) - 9000);
            s.roll_centideg  = 16'($signed($urandom_range(36000)) - 18000);
        end
        s.mag_x = 16'($urandom);
        s.mag_y = 16'($urandom);
        s.mag_z = 16'($urandom);
        if ($urandom_range(9) == 0) s.mag_x = 16'($signed($urandom_range(8)) - 4);
        if ($urandom_range(9) == 0) s.mag_y = 16'($signed($urandom_range(8)) - 4);
        return s;
    endfunction

    initial
    begin
        sample_valid = 1'b0;
        sample       = '0;
        busy_phase   = 1'b0;
        sample_count = 0;
        idle_cycles  = 0;
        rst_n        = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words: zero field, axis-aligned fields in all four
        // directions, field extremes and angles past their nominal ranges.
        send_fields(0, 0, 0, 0, 0);
        send_fields(0, 0, 1000, 0, 0);
        send_fields(0, 0, -1000, 0, 0);
        send_fields(0, 0, 0, 1000, 0);
        send_fields(0, 0, 0, -1000, 0);
        send_fields(0, 0, 1000, 1000, 0);
        send_fields(0, 0, -1000, 1000, 0);
        send_fields(0, 0, 1000, -1000, 0);
        send_fields(0, 0, -1000, -1000, 0);
        send_fields(9000, 0, 0, 500, 0);
        send_fields(-9000, 18000, 32767, 32767, 32767);
        send_fields(9000, -18000, -32768, -32768, -32768);
        send_fields(16383, 32767, 32767, -32768, 1);
        send_fields(-16384, -32768, -32768, 32767, -1);
        send_fields(4500, 4500, 0, 0, 0);
        send_fields(0, 9000, 0, 0, 2000);
        send_fields(0, 0, 0, 0, 2000);
        send_fields(12345, 27000, 7, -9, 3);
        send_fields(-13000, -20000, -1, 1, 0);
        send_fields(0, 0, 1, 0, 0);

        // Let the pipeline drain completely before going on.
        sample_valid <= 1'b0;
        while (pending_count != 0)
            @(posedge clk);

        // Random words, mostly in range, with a stretch of no idling.
        for (int n = 0; n < 450; n++)
        begin
            busy_phase = (n >= 150 && n < 230);
            send_sample(random_sample($urandom_range(9) == 0));
        end
        busy_phase = 1'b0;
        sample_valid <= 1'b0;

        while (pending_count != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);

        $display("Sent %0d sample words, %0d heading words checked (directed cases,",
                 sample_count, heading_count);
        $display("random in-range and raw angles, with random stalls on both sides).");
        if (fail_count == 0 && pending_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
